[rtl/svm_pkg.sv]
// Shared constants, types and helper functions for the spatial voice mixer.
package svm_pkg;

    localparam int STORE_DEPTH = 16384;
    localparam int MAX_FRAMES  = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int ACC_BITS    = 24;

    localparam int COORD_BITS  = 16;
    localparam int DIST2_BITS  = 34;
    localparam int CNT_BITS    = 15;
    localparam int FRAME_BITS  = 13;
    localparam int GAIN_BITS   = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 34;

    localparam logic [16:0] UNITY_GAIN = 17'd32768;

    // Item codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_MIX   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;   // unused code, ignored

    // Configuration register indexes
    localparam logic [2:0] REG_SRC_X    = 3'd0;
    localparam logic [2:0] REG_SRC_Y    = 3'd1;
    localparam logic [2:0] REG_SRC_Z    = 3'd2;
    localparam logic [2:0] REG_MAX_D2   = 3'd3;
    localparam logic [2:0] REG_SCOUNT   = 3'd4;
    localparam logic [2:0] REG_SPATIAL  = 3'd5;
    localparam logic [2:0] REG_STEREO   = 3'd6;
    localparam logic [2:0] REG_LOOPING  = 3'd7;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;     // capture the accepted request
        logic store_wr;    // write sample store
        logic geo_start;   // compute dist2, dot and counts
        logic sqrt_start;  // start the root unit
        logic sqrt_step;
        logic div_start;   // start the divider
        logic div_step;
        logic div_sel_pan; // 0: attenuation division, 1: pan division
        logic gain_mul;    // form the final gains
        logic commit;      // update position and frame counters
        logic unity;       // commit with unity gains
        logic stop_only;   // clear frames_to_mix and the frame counter only
        logic rd_issue;    // read the store
        logic mix_mul;     // multiply samples
        logic mix_out;     // load the result register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic playing;
        logic spatial;
        logic too_far;
        logic len_zero;
        logic step_done;
    } t_sts;

endpackage

[rtl/svm_if.sv]
// Valid/ready channel interfaces for requests, results and configuration.
interface svm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [13:0] sample_index;
    logic signed [15:0] sample_value;
    logic signed [15:0] listener_x;
    logic signed [15:0] listener_y;
    logic signed [15:0] listener_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic [12:0] frame_count;
    logic signed [23:0] acc_left;
    logic signed [23:0] acc_right;
    modport source (output valid, op, sample_index, sample_value, listener_x, listener_y,
                    listener_z, right_x, right_y, right_z, frame_count, acc_left, acc_right,
                    input ready);
    modport sink (input valid, op, sample_index, sample_value, listener_x, listener_y,
                  listener_z, right_x, right_y, right_z, frame_count, acc_left, acc_right,
                  output ready);
endinterface

interface svm_out_if;
    logic        valid;
    logic        ready;
    logic signed [23:0] out_left;
    logic signed [23:0] out_right;
    logic        frame_used;
    logic        still_playing;
    modport source (output valid, out_left, out_right, frame_used, still_playing,
                    input ready);
    modport sink (input valid, out_left, out_right, frame_used, still_playing,
                  output ready);
endinterface

interface svm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [33:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/svm_ctrl.sv]
// Controller state machine sequencing load, begin and mix requests.
module svm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_op,
    output logic           o_in_ready,
    input  logic           i_out_busy,
    input  svm_pkg::t_sts  i_sts,
    output svm_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_GEO    = 4'd2;
    localparam logic [3:0] S_SQRT   = 4'd3;
    localparam logic [3:0] S_DIVA   = 4'd4;
    localparam logic [3:0] S_DIVP   = 4'd5;
    localparam logic [3:0] S_GAIN   = 4'd6;
    localparam logic [3:0] S_COMMIT = 4'd7;
    localparam logic [3:0] S_RD     = 4'd8;
    localparam logic [3:0] S_MUL    = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;
    localparam logic [3:0] S_DIVA0  = 4'd11;
    localparam logic [3:0] S_DIVP0  = 4'd12;

    logic [3:0] r_state, n_state;
    logic [1:0] r_op;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= svm_pkg::OP_LOAD;
        end else begin
            r_state <= n_state;
            if (o_in_ready && i_in_valid) r_op <= i_op;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority case (r_op)
                    svm_pkg::OP_LOAD: begin
                        o_cmd.store_wr = 1'b1;
                        n_state = S_IDLE;
                    end
                    svm_pkg::OP_BEGIN: begin
                        o_cmd.geo_start = 1'b1;
                        n_state = S_GEO;
                    end
                    svm_pkg::OP_MIX: begin
                        o_cmd.rd_issue = 1'b1;
                        n_state = S_RD;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_GEO: begin
                // dist2 and dot are registered here
                if (!i_sts.playing) begin
                    o_cmd.stop_only = 1'b1;
                    n_state = S_IDLE;
                end else if (!i_sts.spatial) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.unity  = 1'b1;
                    n_state = S_IDLE;
                end else if (i_sts.too_far) begin
                    o_cmd.stop_only = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.step_done) n_state = S_DIVA0;
            end
            S_DIVA0: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIVA;
            end
            S_DIVA: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.step_done) n_state = i_sts.len_zero ? S_GAIN : S_DIVP0;
            end
            S_DIVP0: begin
                o_cmd.div_start   = 1'b1;
                o_cmd.div_sel_pan = 1'b1;
                n_state = S_DIVP;
            end
            S_DIVP: begin
                o_cmd.div_step    = 1'b1;
                o_cmd.div_sel_pan = 1'b1;
                if (i_sts.step_done) n_state = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain_mul = 1'b1;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_IDLE;
            end
            S_RD: begin
                o_cmd.mix_mul = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (!i_out_busy) begin
                    o_cmd.mix_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/svm_dp.sv]
// Datapath: configuration, sample store, geometry, root and divide units, mixing.
module svm_dp #(
    parameter int STORE_DEPTH = svm_pkg::STORE_DEPTH,
    parameter int MAX_FRAMES  = svm_pkg::MAX_FRAMES,
    parameter int SAMPLE_BITS = svm_pkg::SAMPLE_BITS,
    parameter int ACC_BITS    = svm_pkg::ACC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  svm_pkg::t_cmd              i_cmd,
    output svm_pkg::t_sts              o_sts,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [33:0]                i_cfg_data,
    // request payload
    input  logic [13:0]                i_sample_index,
    input  logic signed [15:0]         i_sample_value,
    input  logic signed [15:0]         i_listener_x,
    input  logic signed [15:0]         i_listener_y,
    input  logic signed [15:0]         i_listener_z,
    input  logic signed [15:0]         i_right_x,
    input  logic signed [15:0]         i_right_y,
    input  logic signed [15:0]         i_right_z,
    input  logic [12:0]                i_frame_count,
    input  logic signed [23:0]         i_acc_left,
    input  logic signed [23:0]         i_acc_right,
    // result
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic signed [23:0]         o_out_left,
    output logic signed [23:0]         o_out_right,
    output logic                       o_frame_used,
    output logic                       o_still_playing
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int PW = AW + 1;          // position width, holds STORE_DEPTH
    localparam int FW = $clog2(MAX_FRAMES) + 1;
    localparam int SB = SAMPLE_BITS;
    localparam int AB = ACC_BITS;
    localparam int MW = SB + 18;         // sample times gain
    localparam int SW = AB > MW - 15 ? AB + 1 : MW - 14;

    // configuration registers
    logic signed [15:0] r_src_x, r_src_y, r_src_z;
    logic [33:0] r_max_d2;
    logic [14:0] r_scount;
    logic r_spatial, r_stereo, r_looping;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_x <= '0; r_src_y <= '0; r_src_z <= '0;
            r_max_d2 <= '0; r_scount <= 15'd1;
            r_spatial <= 1'b0; r_stereo <= 1'b0; r_looping <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                svm_pkg::REG_SRC_X:   r_src_x   <= i_cfg_data[15:0];
                svm_pkg::REG_SRC_Y:   r_src_y   <= i_cfg_data[15:0];
                svm_pkg::REG_SRC_Z:   r_src_z   <= i_cfg_data[15:0];
                svm_pkg::REG_MAX_D2:  r_max_d2  <= i_cfg_data;
                svm_pkg::REG_SCOUNT:  r_scount  <= i_cfg_data[14:0];
                svm_pkg::REG_SPATIAL: r_spatial <= i_cfg_data[0];
                svm_pkg::REG_STEREO:  r_stereo  <= i_cfg_data[0];
                svm_pkg::REG_LOOPING: r_looping <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // captured request
    logic [13:0] r_idx;
    logic signed [15:0] r_sval, r_lx, r_ly, r_lz, r_rx, r_ry, r_rz;
    logic [12:0] r_fcnt;
    logic signed [23:0] r_accl, r_accr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_idx <= i_sample_index; r_sval <= i_sample_value;
            r_lx <= i_listener_x; r_ly <= i_listener_y; r_lz <= i_listener_z;
            r_rx <= i_right_x; r_ry <= i_right_y; r_rz <= i_right_z;
            r_fcnt <= i_frame_count; r_accl <= i_acc_left; r_accr <= i_acc_right;
        end
    end

    // voice state
    logic [PW-1:0] r_play, r_base;
    logic r_playing;
    logic [16:0] r_gl, r_gr;
    logic [FW-1:0] r_ftm, r_fctr;

    // geometry: differences, squares and products registered in one stage
    logic signed [16:0] dx, dy, dz;
    logic [33:0] d2_c;
    logic signed [35:0] dot_c;
    logic [33:0] r_d2;
    logic signed [35:0] r_dot;
    logic [PW-1:0] r_todo, r_cnt;

    logic [PW-1:0] cnt_c, limit_c, frames_c, remain_c, todo_c;

    always_comb begin
        dx = 17'(r_src_x) - 17'(r_lx);
        dy = 17'(r_src_y) - 17'(r_ly);
        dz = 17'(r_src_z) - 17'(r_lz);
        d2_c = 34'(unsigned'(34'(dx * dx))) + 34'(unsigned'(34'(dy * dy)))
             + 34'(unsigned'(34'(dz * dz)));
        dot_c = 36'(r_rx * dx) + 36'(r_ry * dy) + 36'(r_rz * dz);
        limit_c = r_stereo ? PW'(STORE_DEPTH / 2) : PW'(STORE_DEPTH);
        cnt_c = (r_scount == '0) ? PW'(1) : ((32'(r_scount) > 32'(limit_c)) ? limit_c
                : PW'(r_scount));
        frames_c = (32'(r_fcnt) > 32'(MAX_FRAMES)) ? PW'(MAX_FRAMES) : PW'(r_fcnt);
        remain_c = (r_play < cnt_c) ? cnt_c - r_play : '0;
        todo_c = (frames_c < remain_c) ? frames_c : remain_c;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.geo_start) begin
            r_d2 <= d2_c; r_dot <= dot_c; r_todo <= todo_c; r_cnt <= cnt_c;
        end
    end

    // integer square root, one result bit per pass, one pass a cycle
    logic [33:0] r_sq_v, r_sq_r, r_sq_bit;
    logic [33:0] sq_sum;
    assign sq_sum = r_sq_r + r_sq_bit;
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_sq_v <= r_d2; r_sq_r <= '0; r_sq_bit <= 34'h1_0000_0000;
        end else if (i_cmd.sqrt_step && r_sq_bit != '0) begin
            if (r_sq_v >= sq_sum) begin
                r_sq_v <= r_sq_v - sq_sum;
                r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
            end else begin
                r_sq_r <= r_sq_r >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
    end

    // restoring divider, one quotient bit a cycle
    // attenuation: d2*32768 / max (quotient <= 32768); pan: 3|dot| / (4 len)
    logic [50:0] r_dv_rem;
    logic [50:0] r_dv_num;
    logic [35:0] r_dv_den;
    logic [50:0] r_dv_q;
    logic [5:0]  r_dv_cnt;
    logic [51:0] dv_trial;
    logic [50:0] dv_q_n;
    logic [37:0] adot;
    logic [16:0] r_att;
    logic [16:0] r_mag;
    logic [16:0] quot_c;

    assign adot = 38'(r_dot < 0 ? -r_dot : r_dot) * 38'd3;
    assign dv_trial = {r_dv_rem, r_dv_num[50]} - 52'(r_dv_den);
    // quotient including the bit decided this cycle
    assign dv_q_n = {r_dv_q[49:0], !dv_trial[51]};
    assign quot_c = (dv_q_n > 51'd32768) ? 17'd32768 : 17'(dv_q_n);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dv_rem <= '0; r_dv_q <= '0; r_dv_cnt <= 6'd51;
            if (i_cmd.div_sel_pan) begin
                r_dv_num <= 51'(adot);
                r_dv_den <= 36'({r_sq_r[33:0], 2'b00});
            end else begin
                r_dv_num <= {r_d2, 15'd0, 2'b00};
                r_dv_den <= 36'(r_max_d2);
            end
        end else if (i_cmd.div_step && r_dv_cnt != '0) begin
            if (!dv_trial[51]) begin
                r_dv_rem <= dv_trial[50:0];
                r_dv_q   <= {r_dv_q[49:0], 1'b1};
            end else begin
                r_dv_rem <= {r_dv_rem[49:0], r_dv_num[50]};
                r_dv_q   <= {r_dv_q[49:0], 1'b0};
            end
            r_dv_num <= {r_dv_num[49:0], 1'b0};
            r_dv_cnt <= r_dv_cnt - 6'd1;
        end
    end

    // the numerator of the attenuation division is shifted by 2 to share the
    // 51-bit path: drop those two quotient bits
    logic [50:0] att_q;
    assign att_q = dv_q_n >> 2;

    logic div_done_c;
    assign div_done_c = (r_dv_cnt == 6'd1) && i_cmd.div_step;

    always_ff @(posedge i_clk) begin
        if (div_done_c && !i_cmd.div_sel_pan) begin
            r_att <= (r_max_d2 == '0) ? svm_pkg::UNITY_GAIN
                   : svm_pkg::UNITY_GAIN - 17'(att_q[15:0] == 16'd0 && att_q[16] ? 17'd32768
                   : 17'(att_q));
            r_mag <= '0;
        end else if (div_done_c && i_cmd.div_sel_pan) begin
            r_mag <= quot_c;
        end
    end

    // final gains: volume times attenuation, one multiplier each
    logic [16:0] vol_l, vol_r;
    logic [33:0] gl_p, gr_p;
    always_comb begin
        if (r_dot < 0) begin
            vol_r = svm_pkg::UNITY_GAIN - r_mag; vol_l = svm_pkg::UNITY_GAIN;
        end else begin
            vol_l = svm_pkg::UNITY_GAIN - r_mag; vol_r = svm_pkg::UNITY_GAIN;
        end
        gl_p = vol_l * r_att;
        gr_p = vol_r * r_att;
    end

    logic [16:0] r_ngl, r_ngr;
    always_ff @(posedge i_clk) begin
        if (i_cmd.gain_mul) begin
            r_ngl <= gl_p[31:15]; r_ngr <= gr_p[31:15];
        end
    end

    // voice state update
    logic [PW-1:0] np_c;
    assign np_c = r_play + r_todo;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play <= '0; r_base <= '0; r_playing <= 1'b1;
            r_gl <= '0; r_gr <= '0; r_ftm <= '0; r_fctr <= '0;
        end else if (i_cmd.stop_only) begin
            r_ftm <= '0; r_fctr <= '0;
        end else if (i_cmd.commit) begin
            r_gl <= i_cmd.unity ? svm_pkg::UNITY_GAIN : r_ngl;
            r_gr <= i_cmd.unity ? svm_pkg::UNITY_GAIN : r_ngr;
            r_ftm <= FW'(r_todo); r_fctr <= '0;
            r_base <= r_play;
            if (np_c >= r_cnt) begin
                r_play <= '0;
                if (!r_looping) r_playing <= 1'b0;
            end else begin
                r_play <= np_c;
            end
        end else if (i_cmd.mix_mul && r_fctr < r_ftm) begin
            r_fctr <= r_fctr + FW'(1);
        end
    end

    // sample store, one write port and one read port
    logic [SB-1:0] r_store [STORE_DEPTH];
    logic [SB-1:0] r_rd_l, r_rd_r;
    logic [PW-1:0] pos_c;
    logic [PW:0]   wl_c, wr_c;
    logic          r_use;
    assign pos_c = r_base + PW'(r_fctr);
    assign wl_c  = r_stereo ? {pos_c, 1'b0} : {1'b0, pos_c};
    assign wr_c  = r_stereo ? {pos_c, 1'b1} : {1'b0, pos_c};

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr && 32'(r_idx) < STORE_DEPTH) r_store[r_idx[AW-1:0]] <= r_sval[SB-1:0];
    end

    // the read port is time shared: the left word is read on rd_issue, the right word on mix_mul
    logic [SB-1:0] r_rd_tmp;
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rd_tmp <= r_store[wl_c[AW-1:0]];
            r_use    <= r_fctr < r_ftm;
        end
        if (i_cmd.mix_mul) begin
            r_rd_l <= r_rd_tmp;
            r_rd_r <= r_store[wr_c[AW-1:0]];
        end
    end

    // mix: product, floor shift, saturating add
    logic signed [MW-1:0] pl, pr;
    logic signed [SW-1:0] sl, sr;
    logic signed [AB-1:0] ol, orr;
    localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (AB - 1)) - 1);
    localparam logic signed [SW-1:0] LO = -HI - SW'(1);

    always_comb begin
        pl = MW'($signed(r_rd_l)) * $signed({1'b0, r_gl});
        pr = MW'($signed(r_rd_r)) * $signed({1'b0, r_gr});
        sl = SW'(r_accl) + SW'(pl >>> 15);
        sr = SW'(r_accr) + SW'(pr >>> 15);
        ol  = sl > HI ? AB'(HI) : (sl < LO ? AB'(LO) : AB'(sl));
        orr = sr > HI ? AB'(HI) : (sr < LO ? AB'(LO) : AB'(sr));
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.mix_out) o_out_valid <= 1'b1;
            else if (i_out_ready) o_out_valid <= 1'b0;
        end
        if (i_cmd.mix_out) begin
            o_out_left      <= r_use ? ol : r_accl;
            o_out_right     <= r_use ? orr : r_accr;
            o_frame_used    <= r_use;
            o_still_playing <= r_playing;
        end
    end

    logic r_step_done;
    assign r_step_done = (i_cmd.sqrt_step && r_sq_bit == '0) || div_done_c;

    assign o_sts.playing   = r_playing;
    assign o_sts.spatial   = r_spatial;
    assign o_sts.too_far   = d2_c > r_max_d2;
    assign o_sts.len_zero  = r_sq_r == '0;
    assign o_sts.step_done = r_step_done;

endmodule

[rtl/spatial_voice_mixer_core.sv]
// Top level of the spatial voice mixer: controller, datapath and channel ports.
//
// Requests arrive on the in channel: load writes one store word, begin sets
// up one output buffer (gains, frame count, play position), mix adds one
// gained frame to the incoming accumulator pair and returns one result on
// the out channel. Load and begin return nothing.
// Configuration is written on the cfg channel, which is always ready; write
// it only while the block is idle.
// A load is captured and then written to the store; a mix is captured,
// issues its read, reads and multiplies, then loads the output register.
// Without spatial gains a begin commits unity gains. With them it runs the
// root unit, then attenuation and pan divisions on one shared bit-serial
// divider; the pan division is skipped if the listener sits on the source.
// One request is in work at a time; in ready is high only in the idle state.
// A result waits in the output register while the receiver stalls; a
// following mix holds before its output step until that register frees.
// Reset is synchronous: voice state returns to its initial values; the
// sample store is not cleared and has no clearing pass.
module spatial_voice_mixer_core #(
    parameter int STORE_DEPTH = svm_pkg::STORE_DEPTH,
    parameter int MAX_FRAMES  = svm_pkg::MAX_FRAMES,
    parameter int SAMPLE_BITS = svm_pkg::SAMPLE_BITS,
    parameter int ACC_BITS    = svm_pkg::ACC_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    svm_in_if.sink    in_ch,
    svm_out_if.source out_ch,
    svm_cfg_if.sink   cfg_ch
);

    svm_pkg::t_cmd cmd;
    svm_pkg::t_sts sts;
    logic in_ready;

    assign in_ch.ready  = in_ready;
    assign cfg_ch.ready = 1'b1;

    svm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_op       (in_ch.op),
        .o_in_ready (in_ready),
        .i_out_busy (out_ch.valid && !out_ch.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    svm_dp #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (cfg_ch.valid),
        .i_cfg_idx       (cfg_ch.index),
        .i_cfg_data      (cfg_ch.data),
        .i_sample_index  (in_ch.sample_index),
        .i_sample_value  (in_ch.sample_value),
        .i_listener_x    (in_ch.listener_x),
        .i_listener_y    (in_ch.listener_y),
        .i_listener_z    (in_ch.listener_z),
        .i_right_x       (in_ch.right_x),
        .i_right_y       (in_ch.right_y),
        .i_right_z       (in_ch.right_z),
        .i_frame_count   (in_ch.frame_count),
        .i_acc_left      (in_ch.acc_left),
        .i_acc_right     (in_ch.acc_right),
        .i_out_ready     (out_ch.ready),
        .o_out_valid     (out_ch.valid),
        .o_out_left      (out_ch.out_left),
        .o_out_right     (out_ch.out_right),
        .o_frame_used    (out_ch.frame_used),
        .o_still_playing (out_ch.still_playing)
    );

    // commit and stop_only are never issued together
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.commit && cmd.stop_only))
        else $error("commit and stop issued together");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mix_out |-> !(out_ch.valid && !out_ch.ready))
        else $error("result register overwritten");

    a_valid_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mix_out |=> out_ch.valid)
        else $error("result not shown");

endmodule
